// ===== hdl/evhp_pkg.sv =====
// ----------------------------------------------------------------------------
// evhp_pkg
// Shared types and constants for the Ethernet II / 802.1Q / QinQ header parser.
// ----------------------------------------------------------------------------
package evhp_pkg;

  localparam int MAC_W      = 48;
  localparam int WORD_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 11;
  localparam int TAGS_W     = 2;
  localparam int HLEN_W     = 5;
  localparam int ST_W       = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // byte positions within the frame
  localparam logic [CNT_W-1:0] IDX_SRC_START = 11'd6;
  localparam logic [CNT_W-1:0] IDX_TYPE_START = 11'd12;
  localparam logic [CNT_W-1:0] IDX_FIRST_TYPE = 11'd13;
  localparam logic [CNT_W-1:0] IDX_OUTER_TCI = 11'd15;
  localparam logic [CNT_W-1:0] IDX_SECOND_TYPE = 11'd17;
  localparam logic [CNT_W-1:0] IDX_INNER_TCI = 11'd19;
  localparam logic [CNT_W-1:0] IDX_THIRD_TYPE = 11'd21;

  // minimum lengths per parse stage
  localparam logic [CNT_W-1:0] LEN_BASE       = 11'd14;
  localparam logic [CNT_W-1:0] LEN_OUTER_TCI  = 11'd16;
  localparam logic [CNT_W-1:0] LEN_OUTER_TYPE = 11'd18;
  localparam logic [CNT_W-1:0] LEN_INNER_TCI  = 11'd20;
  localparam logic [CNT_W-1:0] LEN_INNER_TYPE = 11'd22;

  localparam logic [HLEN_W-1:0] HLEN_UNTAGGED = 5'd14;
  localparam logic [HLEN_W-1:0] HLEN_ONE_TAG  = 5'd18;
  localparam logic [HLEN_W-1:0] HLEN_TWO_TAGS = 5'd22;

  localparam logic [TAGS_W-1:0] TAGS_NONE = 2'd0;
  localparam logic [TAGS_W-1:0] TAGS_ONE  = 2'd1;
  localparam logic [TAGS_W-1:0] TAGS_TWO  = 2'd2;

  localparam logic [WORD_W-1:0] VLAN_TPID_RST = 16'h8100;
  localparam logic [WORD_W-1:0] QINQ_TPID_RST = 16'h88A8;
  localparam logic [CNT_W-1:0]  MIN_FRAME_RST = 11'd14;

  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_SHORT,
    ST_OUTER_CUT,
    ST_OUTER_TYPE_CUT,
    ST_INNER_CUT,
    ST_INNER_TYPE_CUT
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_VLAN_TPID,
    CFG_QINQ_TPID,
    CFG_MIN_FRAME
  } cfg_addr_t;

  typedef struct packed {
    logic [WORD_W-1:0] vlan_tpid;
    logic [WORD_W-1:0] qinq_tpid;
    logic [CNT_W-1:0]  min_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;
  } beat_t;

  typedef struct packed {
    logic [MAC_W-1:0]  dst_mac;
    logic [MAC_W-1:0]  src_mac;
    logic [WORD_W-1:0] ether_type;
    logic [TAGS_W-1:0] tag_count;
    logic [WORD_W-1:0] outer_tpid;
    logic [WORD_W-1:0] outer_tci;
    logic [WORD_W-1:0] inner_tpid;
    logic [WORD_W-1:0] inner_tci;
    logic [HLEN_W-1:0] hdr_bytes;
    status_t           status;
  } hdr_t;

endpackage

// ===== hdl/evhp_if.sv =====
// ----------------------------------------------------------------------------
// evhp_if
// Channel interfaces: frame byte input, header result output, config writes.
// ----------------------------------------------------------------------------
interface evhp_in_if import evhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface evhp_out_if import evhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MAC_W-1:0]  dst_mac;
  logic [MAC_W-1:0]  src_mac;
  logic [WORD_W-1:0] ether_type;
  logic [TAGS_W-1:0] tag_count;
  logic [WORD_W-1:0] outer_tpid;
  logic [WORD_W-1:0] outer_tci;
  logic [WORD_W-1:0] inner_tpid;
  logic [WORD_W-1:0] inner_tci;
  logic [HLEN_W-1:0] hdr_bytes;
  logic [ST_W-1:0]   status;

  modport source (
    output valid, output dst_mac, output src_mac, output ether_type, output tag_count,
    output outer_tpid, output outer_tci, output inner_tpid, output inner_tci,
    output hdr_bytes, output status, input ready
  );
  modport sink (
    input valid, input dst_mac, input src_mac, input ether_type, input tag_count,
    input outer_tpid, input outer_tci, input inner_tpid, input inner_tci,
    input hdr_bytes, input status, output ready
  );
endinterface

interface evhp_cfg_if import evhp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

// ===== hdl/evhp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// evhp_cfg_regs
// Tag identifier and minimum frame length registers.
// ----------------------------------------------------------------------------
module evhp_cfg_regs import evhp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_ADDR_W-1:0] wr_addr,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_addr_t'(wr_addr))
        CFG_VLAN_TPID: cfg_nxt.vlan_tpid = wr_data;
        CFG_QINQ_TPID: cfg_nxt.qinq_tpid = wr_data;
        CFG_MIN_FRAME: cfg_nxt.min_frame_bytes = wr_data[CNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vlan_tpid       <= VLAN_TPID_RST;
      cfg_r.qinq_tpid       <= QINQ_TPID_RST;
      cfg_r.min_frame_bytes <= MIN_FRAME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/evhp_in_stage.sv =====
// ----------------------------------------------------------------------------
// evhp_in_stage
// Input register for one byte beat; releases it when the parser can take it.
// ----------------------------------------------------------------------------
module evhp_in_stage import evhp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  beat_t in_beat,
  input  logic  out_ok,
  output logic  proc,
  output beat_t beat
);

  logic  valid_r;
  logic  valid_nxt;
  beat_t beat_r;
  logic  take;

  // last beat needs a free result slot; other beats always drain
  assign proc     = valid_r && (!beat_r.last_byte || out_ok);
  assign in_ready = !valid_r || proc;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (proc) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_r <= in_beat;
    end
  end

  assign beat = beat_r;

  a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !proc |=> valid_r && $stable(beat_r))
    else $error("held beat changed while stalled");

endmodule

// ===== hdl/evhp_capture.sv =====
// ----------------------------------------------------------------------------
// evhp_capture
// Frame byte counter, header field capture and end-of-frame result decode.
// ----------------------------------------------------------------------------
module evhp_capture import evhp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  proc,
  input  beat_t beat,
  output hdr_t  res
);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MAC_W-1:0]  dst_r, dst_nxt;
  logic [MAC_W-1:0]  src_r, src_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] type1_r, type1_nxt;
  logic [WORD_W-1:0] otci_r, otci_nxt;
  logic [WORD_W-1:0] type2_r, type2_nxt;
  logic [WORD_W-1:0] itci_r, itci_nxt;
  logic [WORD_W-1:0] type3_r, type3_nxt;
  logic              tag1;
  logic              tag2;
  status_t           status;
  logic [TAGS_W-1:0] tags;
  logic [HLEN_W-1:0] hlen;

  always_comb begin
    word_nxt  = {word_r[BYTE_W-1:0], beat.frame_byte};
    dst_nxt   = dst_r;
    src_nxt   = src_r;
    type1_nxt = type1_r;
    otci_nxt  = otci_r;
    type2_nxt = type2_r;
    itci_nxt  = itci_r;
    type3_nxt = type3_r;
    if (cnt_r < IDX_SRC_START) begin
      dst_nxt = {dst_r[MAC_W-BYTE_W-1:0], beat.frame_byte};
    end else if (cnt_r < IDX_TYPE_START) begin
      src_nxt = {src_r[MAC_W-BYTE_W-1:0], beat.frame_byte};
    end
    if (cnt_r == IDX_FIRST_TYPE) type1_nxt = word_nxt;
    if (cnt_r == IDX_OUTER_TCI) otci_nxt = word_nxt;
    if (cnt_r == IDX_SECOND_TYPE) type2_nxt = word_nxt;
    if (cnt_r == IDX_INNER_TCI) itci_nxt = word_nxt;
    if (cnt_r == IDX_THIRD_TYPE) type3_nxt = word_nxt;
    cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  end

  assign tag1 = (type1_nxt == cfg.vlan_tpid) || (type1_nxt == cfg.qinq_tpid);
  assign tag2 = (type2_nxt == cfg.vlan_tpid) || (type2_nxt == cfg.qinq_tpid);

  // cnt_nxt is the frame length once this byte is counted
  always_comb begin
    status = ST_OK;
    tags   = TAGS_NONE;
    hlen   = HLEN_UNTAGGED;
    if (cnt_nxt < cfg.min_frame_bytes || cnt_nxt < LEN_BASE) begin
      status = ST_SHORT;
    end else if (tag1) begin
      if (cnt_nxt < LEN_OUTER_TCI) begin
        status = ST_OUTER_CUT;
      end else if (cnt_nxt < LEN_OUTER_TYPE) begin
        status = ST_OUTER_TYPE_CUT;
      end else if (tag2) begin
        if (cnt_nxt < LEN_INNER_TCI) begin
          status = ST_INNER_CUT;
        end else if (cnt_nxt < LEN_INNER_TYPE) begin
          status = ST_INNER_TYPE_CUT;
        end else begin
          tags = TAGS_TWO;
          hlen = HLEN_TWO_TAGS;
        end
      end else begin
        tags = TAGS_ONE;
        hlen = HLEN_ONE_TAG;
      end
    end
  end

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.dst_mac   = dst_nxt;
      res.src_mac   = src_nxt;
      res.tag_count = tags;
      res.hdr_bytes = hlen;
      case (tags)
        TAGS_NONE: begin
          res.ether_type = type1_nxt;
        end
        TAGS_ONE: begin
          res.outer_tpid = type1_nxt;
          res.outer_tci  = otci_nxt;
          res.ether_type = type2_nxt;
        end
        TAGS_TWO: begin
          res.outer_tpid = type1_nxt;
          res.outer_tci  = otci_nxt;
          res.inner_tpid = type2_nxt;
          res.inner_tci  = itci_nxt;
          res.ether_type = type3_nxt;
        end
        default: res.ether_type = type1_nxt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (proc) begin
      cnt_r <= beat.last_byte ? '0 : cnt_nxt;
    end
  end

  // field registers are always rewritten within a frame before use
  always_ff @(posedge clk) begin
    if (proc) begin
      word_r  <= word_nxt;
      dst_r   <= dst_nxt;
      src_r   <= src_nxt;
      type1_r <= type1_nxt;
      otci_r  <= otci_nxt;
      type2_r <= type2_nxt;
      itci_r  <= itci_nxt;
      type3_r <= type3_nxt;
    end
  end

  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    proc && beat.last_byte |=> cnt_r == '0)
    else $error("byte count not cleared after frame end");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !beat.last_byte && cnt_r == CNT_MAX |=> cnt_r == CNT_MAX)
    else $error("byte count wrapped");

endmodule

// ===== hdl/evhp_out_stage.sv =====
// ----------------------------------------------------------------------------
// evhp_out_stage
// Result register holding one header beat until the sink takes it.
// ----------------------------------------------------------------------------
module evhp_out_stage import evhp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  hdr_t res,
  input  logic out_ready,
  output logic out_valid,
  output logic out_ok,
  output hdr_t out_res
);

  logic valid_r;
  logic valid_nxt;
  hdr_t res_r;

  assign out_ok = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_ok)
    else $error("result loaded over a pending beat");

endmodule

// ===== hdl/ethernet_vlan_header_parser.sv =====
// ----------------------------------------------------------------------------
// ethernet_vlan_header_parser
// Ethernet II header parser with 802.1Q and QinQ tag capture.
// The decoded header is loaded into the result register when the last byte leaves the input register.
// Throughput: one byte per cycle; capture and decode are one combinational
// pass between the input register and the result register.
// A last byte waits in the input register while an untaken result is held.
// Reset: clears beat valids and the byte count; config returns to 0x8100,
// 0x88A8 and a 14-byte minimum.
// ----------------------------------------------------------------------------
module ethernet_vlan_header_parser import evhp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  evhp_in_if.sink        in_ch,
  evhp_out_if.source     out_ch,
  evhp_cfg_if.sink       cfg_ch
);

  cfg_t  cfg;
  beat_t in_beat;
  beat_t beat;
  logic  proc;
  logic  out_ok;
  hdr_t  res;
  hdr_t  out_res;

  assign cfg_ch.ready = 1'b1;

  evhp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_addr (cfg_ch.addr),
    .wr_data (cfg_ch.wdata),
    .cfg     (cfg)
  );

  assign in_beat.frame_byte = in_ch.frame_byte;
  assign in_beat.last_byte  = in_ch.last_byte;

  evhp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_beat  (in_beat),
    .out_ok   (out_ok),
    .proc     (proc),
    .beat     (beat)
  );

  evhp_capture u_cap (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .proc  (proc),
    .beat  (beat),
    .res   (res)
  );

  evhp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc && beat.last_byte),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_ok    (out_ok),
    .out_res   (out_res)
  );

  assign out_ch.dst_mac    = out_res.dst_mac;
  assign out_ch.src_mac    = out_res.src_mac;
  assign out_ch.ether_type = out_res.ether_type;
  assign out_ch.tag_count  = out_res.tag_count;
  assign out_ch.outer_tpid = out_res.outer_tpid;
  assign out_ch.outer_tci  = out_res.outer_tci;
  assign out_ch.inner_tpid = out_res.inner_tpid;
  assign out_ch.inner_tci  = out_res.inner_tci;
  assign out_ch.hdr_bytes  = out_res.hdr_bytes;
  assign out_ch.status     = out_res.status;

  a_hlen_tags: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_res.status == ST_OK |->
      (out_res.tag_count == TAGS_NONE && out_res.hdr_bytes == HLEN_UNTAGGED) ||
      (out_res.tag_count == TAGS_ONE && out_res.hdr_bytes == HLEN_ONE_TAG) ||
      (out_res.tag_count == TAGS_TWO && out_res.hdr_bytes == HLEN_TWO_TAGS))
    else $error("header length does not match tag count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_res.status != ST_OK |->
      out_res.hdr_bytes == '0 && out_res.tag_count == '0 &&
      out_res.dst_mac == '0 && out_res.ether_type == '0)
    else $error("error result carries header fields");

endmodule
